[rtl/cse_pkg.sv]
// ----------------------------------------------------------------------------
// Cosine similarity engine package
// Shared widths, payload structures and sequencer states.
// ----------------------------------------------------------------------------
package cse_pkg;

  localparam int unsigned ElemBits = 16;
  localparam int unsigned DotW     = 44;
  localparam int unsigned NormW    = 43;
  localparam int unsigned ProdW    = 2 * NormW + 2;   // 88-bit norm product
  localparam int unsigned RootW    = 44;
  localparam int unsigned RemW     = RootW + 3;
  localparam int unsigned NumW     = DotW + 15;       // dividend width
  localparam int unsigned CntW     = 7;

  typedef struct packed {
    logic signed [ElemBits-1:0] elem_a;
    logic signed [ElemBits-1:0] elem_b;
    logic                       last_elem;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] similarity;
    logic               zero_norm;
  } out_item_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MACAB = 8'b0000_0010,
    ST_MACAA = 8'b0000_0100,
    ST_MACBB = 8'b0000_1000,
    ST_CHECK = 8'b0001_0000,
    ST_NPROD = 8'b0010_0000,
    ST_SQRT  = 8'b0100_0000,
    ST_DIV   = 8'b1000_0000
  } state_e;

endpackage

[rtl/cosine_similarity_engine_unit.sv]
// ----------------------------------------------------------------------------
// Cosine similarity engine
// Accumulates a dot product and two squared norms and emits their cosine.
// ----------------------------------------------------------------------------
// Usage:
// An element pair is transferred at a rising edge where start_i is high and
// busy_o is low. The block then stays busy while one shared 16x16 signed
// multiplier adds a*b, a*a and b*b into the accumulators, one product per
// cycle, and it takes no new pair until it has returned to idle.
// For the pair marked last_elem, a check state follows. If either norm is
// zero, the result (similarity 0, zero_norm 1) is presented right away.
// Otherwise the norm product is built by shift-and-add, its floor square
// root by a two-bit-per-cycle restoring recurrence, and the quotient by
// restoring division one bit per cycle; the long division loop dominates.
// The result is shown on result_o for exactly one cycle with done_o high;
// the receiver cannot stall it, so it must take it in that cycle.
// After the result the accumulators are clear for the next pair of vectors.
// Reset clears the accumulators, the sequencer and the strobe.
// ----------------------------------------------------------------------------
module cosine_similarity_engine_unit
  import cse_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  in_item_t  in_item_i,
  output logic      busy_o,
  output logic      done_o,
  output out_item_t result_o
);

  state_e state_q, state_d;

  logic signed [ElemBits-1:0] a_q, b_q;
  logic                       last_q;

  logic signed [DotW-1:0] dot_q;
  logic [NormW-1:0]       na_q, nb_q;

  logic [ProdW-1:0]  wide_q;   // norm product, then dividend/quotient
  logic [ProdW-1:0]  aux_q;    // shifted multiplicand
  logic [NormW-1:0]  mb_q;     // multiplier bits, consumed from the bottom
  logic [RemW-1:0]   rem_q;
  logic [RootW-1:0]  root_q;
  logic              neg_q;
  logic [CntW-1:0]   cnt_q;

  logic      done_q;
  out_item_t res_q;

  // Shared multiplier: operand selection by sequencer state.
  logic signed [ElemBits-1:0]   mx, my;
  logic signed [2*ElemBits-1:0] prod;

  always_comb begin
    mx = a_q;
    my = b_q;
    unique case (state_q)
      ST_MACAA: my = a_q;
      ST_MACBB: mx = b_q;
      default: ;
    endcase
  end

  assign prod = mx * my;

  // Square root step: bring down two bits and try root*4+1.
  logic [RemW-1:0] sq_rem, sq_trial;
  assign sq_rem   = {rem_q[RemW-3:0], wide_q[ProdW-1 -: 2]};
  assign sq_trial = {1'b0, root_q, 2'b01};

  // Division step: bring down one dividend bit and try the root.
  logic [RootW:0] dv_rem;
  assign dv_rem = {rem_q[RootW-1:0], wide_q[NumW-1]};

  logic [DotW-1:0] dot_mag;
  assign dot_mag = dot_q[DotW-1] ? DotW'(-dot_q) : DotW'(dot_q);

  logic [NumW-1:0] quot;
  assign quot = wide_q[NumW-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start_i) state_d = ST_MACAB;
      ST_MACAB: state_d = ST_MACAA;
      ST_MACAA: state_d = ST_MACBB;
      ST_MACBB: state_d = last_q ? ST_CHECK : ST_IDLE;
      ST_CHECK: state_d = (na_q == '0 || nb_q == '0) ? ST_IDLE : ST_NPROD;
      ST_NPROD: if (cnt_q == CntW'(NormW - 1)) state_d = ST_SQRT;
      ST_SQRT:  if (cnt_q == CntW'(RootW - 1)) state_d = ST_DIV;
      ST_DIV:   if (cnt_q == CntW'(NumW - 1)) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dot_q   <= '0;
      na_q    <= '0;
      nb_q    <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      unique case (state_q)
        ST_MACAB: dot_q <= dot_q + DotW'(prod);
        ST_MACAA: na_q  <= na_q + NormW'(unsigned'(prod));
        ST_MACBB: nb_q  <= nb_q + NormW'(unsigned'(prod));
        ST_CHECK: begin
          cnt_q <= '0;
          if (na_q == '0 || nb_q == '0) begin
            done_q <= 1'b1;
            dot_q  <= '0;
            na_q   <= '0;
            nb_q   <= '0;
          end
        end
        ST_NPROD, ST_SQRT: begin
          cnt_q <= (state_d == state_q) ? cnt_q + 1'b1 : '0;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(NumW - 1)) begin
            done_q <= 1'b1;
            dot_q  <= '0;
            na_q   <= '0;
            nb_q   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          a_q    <= in_item_i.elem_a;
          b_q    <= in_item_i.elem_b;
          last_q <= in_item_i.last_elem;
        end
      end
      ST_CHECK: begin
        wide_q <= '0;
        aux_q  <= ProdW'(na_q);
        mb_q   <= nb_q;
        res_q  <= '{similarity: 16'sd0, zero_norm: 1'b1};
      end
      ST_NPROD: begin
        if (mb_q[0]) wide_q <= wide_q + aux_q;
        aux_q <= aux_q << 1;
        mb_q  <= mb_q >> 1;
        rem_q  <= '0;
        root_q <= '0;
      end
      ST_SQRT: begin
        if (sq_rem >= sq_trial) begin
          rem_q  <= sq_rem - sq_trial;
          root_q <= {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_q  <= sq_rem;
          root_q <= {root_q[RootW-2:0], 1'b0};
        end
        if (cnt_q == CntW'(RootW - 1)) begin
          // Load the dividend |dot| * 2^15 for the division pass.
          wide_q <= ProdW'({dot_mag, 15'd0});
          neg_q  <= dot_q[DotW-1];
        end else begin
          wide_q <= wide_q << 2;
        end
      end
      ST_DIV: begin
        if ((cnt_q == '0 ? {{RootW{1'b0}}, wide_q[NumW-1]} : dv_rem)
            >= {1'b0, root_q}) begin
          rem_q  <= RemW'((cnt_q == '0 ? {{RootW{1'b0}}, wide_q[NumW-1]} : dv_rem)
                          - {1'b0, root_q});
          wide_q <= {wide_q[ProdW-2:0], 1'b1};
        end else begin
          rem_q  <= RemW'(cnt_q == '0 ? {{RootW{1'b0}}, wide_q[NumW-1]} : dv_rem);
          wide_q <= {wide_q[ProdW-2:0], 1'b0};
        end
      end
      default: ;
    endcase
    if (state_q == ST_DIV && cnt_q == CntW'(NumW - 1)) begin
      res_q.zero_norm <= 1'b0;
    end
  end

  // The final quotient bit lands in wide_q at the same edge that raises done_o,
  // so the result is formed from the settled quotient here.
  logic signed [15:0] sat_val;
  always_comb begin
    if (neg_q) begin
      sat_val = (quot > NumW'(32768)) ? -16'sd32768 : 16'(-quot);
    end else begin
      sat_val = (quot > NumW'(32767)) ? 16'sd32767 : 16'(quot);
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign result_o.zero_norm  = res_q.zero_norm;
  assign result_o.similarity = res_q.zero_norm ? 16'sd0 : sat_val;

  // Assertions
  a_state_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("sequencer state not one-hot");

  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o)) else $error("result without a busy phase");

  a_done_acc_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (dot_q == '0 && na_q == '0 && nb_q == '0))
    else $error("accumulators not cleared with result");

  a_idle_after_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("busy while presenting result");

endmodule

[tb/tb_cosine_similarity_engine_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine similarity checker
// Watches element pair transfers and result strobes, predicts each cosine
// from its own exact accumulators and compares it field by field.
// ----------------------------------------------------------------------------
module tb_cosine_similarity_engine_checker
  import cse_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  in_item_t  in_item_i,
  input  logic      busy_i,
  input  logic      done_i,
  input  out_item_t result_i,
  output int        errors_o,
  output int        pending_o
);

  logic [DotW-1:0]  dot_sum;
  logic [NormW-1:0] energy_a;
  logic [NormW-1:0] energy_b;
  out_item_t        cosine_q[$];

  // Floor square root of an 88-bit value, one result bit at a time.
  function automatic logic [RootW-1:0] floor_root(input logic [ProdW-1:0] val);
    logic [RootW-1:0] root;
    logic [RootW-1:0] cand;
    root = '0;
    for (int bit_idx = RootW - 1; bit_idx >= 0; bit_idx--) begin
      cand = root | (RootW'(1) << bit_idx);
      if (ProdW'(cand) * ProdW'(cand) <= val) root = cand;
    end
    return root;
  endfunction

  function automatic out_item_t cosine_of(input logic [DotW-1:0] dot,
                                          input logic [NormW-1:0] na,
                                          input logic [NormW-1:0] nb);
    out_item_t        res;
    logic [RootW-1:0] root;
    logic [DotW-1:0]  mag;
    logic [NumW-1:0]  quo;
    logic             neg;
    res = '0;
    if (na == 0 || nb == 0) begin
      res.zero_norm = 1'b1;
    end else begin
      root = floor_root(ProdW'(na) * ProdW'(nb));
      neg  = dot[DotW-1];
      mag  = neg ? -dot : dot;
      quo  = {mag, 15'b0} / NumW'(root);
      if (neg) begin
        if (quo > NumW'(32768)) quo = NumW'(32768);
        res.similarity = -quo[15:0];
      end else begin
        if (quo > NumW'(32767)) quo = NumW'(32767);
        res.similarity = quo[15:0];
      end
    end
    return res;
  endfunction

  assign pending_o = cosine_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [31:0] pa, pb, pab;
    logic [DotW-1:0]    nd;
    logic [NormW-1:0]   nna, nnb;
    out_item_t          exp_res;
    if (!rst_ni) begin
      dot_sum  <= '0;
      energy_a <= '0;
      energy_b <= '0;
      errors_o <= 0;
    end else begin
      if (done_i) begin
        if (cosine_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time,
                   result_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_res = cosine_q.pop_front();
          if (result_i.similarity !== exp_res.similarity ||
              result_i.zero_norm !== exp_res.zero_norm) begin
            $display("%0t: mismatch similarity/zero_norm expected %0d/%0b actual %0d/%0b",
                     $time, exp_res.similarity, exp_res.zero_norm,
                     result_i.similarity, result_i.zero_norm);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (start_i && !busy_i) begin
        pab = in_item_i.elem_a * in_item_i.elem_b;
        pa  = in_item_i.elem_a * in_item_i.elem_a;
        pb  = in_item_i.elem_b * in_item_i.elem_b;
        nd  = dot_sum + DotW'(signed'(pab));
        nna = energy_a + NormW'(unsigned'(pa));
        nnb = energy_b + NormW'(unsigned'(pb));
        if (in_item_i.last_elem) begin
          cosine_q.insert(cosine_q.size(), cosine_of(nd, nna, nnb));
          dot_sum  <= '0;
          energy_a <= '0;
          energy_b <= '0;
        end else begin
          dot_sum  <= nd;
          energy_a <= nna;
          energy_b <= nnb;
        end
      end
    end
  end

endmodule

[tb/tb_cosine_similarity_engine_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine similarity engine testbench
// Streams directed and random vector pairs into the engine with random gaps;
// a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_cosine_similarity_engine_unit;
  import cse_pkg::*;

  // The limit is generous against the slowest item plus long gaps.
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned NumRandom  = 830;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start_i = 1'b0;
  in_item_t  in_item_i = '0;
  logic      busy_o;
  logic      done_o;
  out_item_t result_o;
  int        errors;
  int        pending;
  int        cycles = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  cosine_similarity_engine_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .in_item_i(in_item_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .result_o (result_o)
  );

  tb_cosine_similarity_engine_checker checker_i (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .in_item_i(in_item_i),
    .busy_i   (busy_o),
    .done_i   (done_o),
    .result_i (result_o),
    .errors_o (errors),
    .pending_o(pending)
  );

  // The cycle counter is the only watchdog; it fires on any hang.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb_cosine_similarity_engine_unit: FAIL");
      $finish;
    end
  end

  // Drive one element pair and hold start until the transfer happens. The
  // start bit stays high across back-to-back transfers, so it is only lowered
  // when an idle gap actually follows.
  task automatic send_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                           input logic last);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i   <= 1'b1;
    in_item_i <= '{elem_a: a, elem_b: b, last_elem: last};
    do @(posedge clk_i); while (busy_o);
  endtask

  // Random element: half full range, the rest extremes, zeros and small values.
  function automatic logic [15:0] rand_elem();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int sent;
    int len;
    int mode;
    logic [15:0] a, b;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: identical, opposite, zero norm on either side, extremes,
    // a result that saturates at +1.0 and one that reaches -1.0 exactly.
    send_pair(16'sh7fff, 16'sh7fff, 1'b1);
    send_pair(16'sh8000, 16'sh7fff, 1'b1);
    send_pair(16'sh8000, 16'sh8000, 1'b1);
    send_pair(16'sh0000, 16'sh1234, 1'b1);
    send_pair(16'sh4321, 16'sh0000, 1'b1);
    send_pair(16'sh0000, 16'sh0000, 1'b0);
    send_pair(16'sh0000, 16'sh0000, 1'b1);
    send_pair(16'sh0001, 16'sh0001, 1'b0);
    send_pair(16'sh0001, 16'sh0001, 1'b1);
    send_pair(16'shffff, 16'sh0001, 1'b0);
    send_pair(16'shffff, 16'sh0001, 1'b1);
    send_pair(16'sh0003, 16'sh0000, 1'b0);
    send_pair(16'sh0000, 16'sh0004, 1'b1);
    send_pair(16'sh5555, 16'shaaaa, 1'b0);
    send_pair(16'shaaaa, 16'sh5555, 1'b0);
    send_pair(16'sh7fff, 16'sh8000, 1'b1);
    sent = 16;

    // Random vector pairs: mostly short, some long; correlated, opposite or
    // independent content so the similarity spreads over its whole range.
    while (sent < NumRandom) begin
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      mode = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) begin
        a = rand_elem();
        case (mode)
          0:       b = a;
          1:       b = -a;
          2:       b = a + 16'($urandom_range(0, 63)) - 16'd32;
          default: b = rand_elem();
        endcase
        send_pair(a, b, i == len - 1);
        sent++;
      end
    end
    start_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_cosine_similarity_engine_unit: PASS");
    end else begin
      $display("tb_cosine_similarity_engine_unit: FAIL");
    end
    $finish;
  end

endmodule
